/* sv/npl_pkg.sv */
// Shared types and constants for the nearest point lookup table.
package npl_pkg;

    localparam int HANDLE_W     = 16;
    localparam int STATUS_W     = 3;
    localparam int DIST_W       = 34;
    localparam int DRAIN_CYCLES = 4;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_REPLACED = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_HIT      = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic clear;
        logic feed;
    } t_dist_ctl;

endpackage

/* sv/npl_cell.sv */
// One storage cell of the rotating entry ring.
module npl_cell #(
    parameter int W = 65
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_shift,
    input  logic         i_load,
    input  logic [W-1:0] i_prev,
    input  logic [W-1:0] i_load_data,
    output logic [W-1:0] o_data
);
    logic         r_valid;
    logic [W-2:0] r_body;

    // The top bit is the valid mark; only it is cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_load_data[W-1];
        end else if (i_shift) begin
            r_valid <= i_prev[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_body <= i_load_data[W-2:0];
        end else if (i_shift) begin
            r_body <= i_prev[W-2:0];
        end
    end

    assign o_data = {r_valid, r_body};

endmodule

/* sv/npl_dist.sv */
// Pipelined squared distance unit with running nearest entry selection.
module npl_dist #(
    parameter int CW = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  npl_pkg::t_dist_ctl        i_ctl,
    input  logic signed [CW-1:0]      i_qx,
    input  logic signed [CW-1:0]      i_qy,
    input  logic signed [CW-1:0]      i_qz,
    input  logic signed [CW-1:0]      i_ex,
    input  logic signed [CW-1:0]      i_ey,
    input  logic signed [CW-1:0]      i_ez,
    input  logic [npl_pkg::HANDLE_W-1:0] i_eh,
    output logic                      o_have,
    output logic [npl_pkg::DIST_W-1:0]   o_best_dist,
    output logic [npl_pkg::HANDLE_W-1:0] o_best_handle
);
    import npl_pkg::*;

    localparam int DW    = CW + 1;
    localparam int SQW   = 2 * CW + 1;
    localparam int SUM_W = SQW + 2;

    // Stage 1: differences.
    logic                   r_s1_v;
    logic signed [DW-1:0]   r_dx, r_dy, r_dz;
    logic signed [CW-1:0]   r_s1_x, r_s1_y, r_s1_z;
    logic [HANDLE_W-1:0]    r_s1_h;
    // Stage 2: squares.
    logic                   r_s2_v;
    logic [SQW-1:0]         r_sqx, r_sqy, r_sqz;
    logic signed [CW-1:0]   r_s2_x, r_s2_y, r_s2_z;
    logic [HANDLE_W-1:0]    r_s2_h;
    // Stage 3: sum.
    logic                   r_s3_v;
    logic [DIST_W-1:0]      r_sum;
    logic signed [CW-1:0]   r_s3_x, r_s3_y, r_s3_z;
    logic [HANDLE_W-1:0]    r_s3_h;
    // Best so far.
    logic                   r_have;
    logic [DIST_W-1:0]      r_best;
    logic signed [CW-1:0]   r_bx, r_by, r_bz;
    logic [HANDLE_W-1:0]    r_bh;

    logic signed [2*DW-1:0] w_px, w_py, w_pz;
    logic [SUM_W-1:0]       w_sum;
    logic                   w_lex_less;
    logic                   w_take;

    assign w_px  = r_dx * r_dx;
    assign w_py  = r_dy * r_dy;
    assign w_pz  = r_dz * r_dz;
    // The true sum is below three times 2^(2*CW), so it always fits the field.
    assign w_sum = SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);

    assign w_lex_less = (r_s3_x != r_bx) ? (r_s3_x < r_bx) :
                        (r_s3_y != r_by) ? (r_s3_y < r_by) :
                                           (r_s3_z < r_bz);
    assign w_take = r_s3_v && (!r_have || (r_sum < r_best) ||
                    ((r_sum == r_best) && w_lex_less));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_s1_v <= i_ctl.feed;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (i_ctl.clear) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= DW'(i_qx) - DW'(i_ex);
        r_dy   <= DW'(i_qy) - DW'(i_ey);
        r_dz   <= DW'(i_qz) - DW'(i_ez);
        r_s1_x <= i_ex;
        r_s1_y <= i_ey;
        r_s1_z <= i_ez;
        r_s1_h <= i_eh;

        r_sqx  <= w_px[SQW-1:0];
        r_sqy  <= w_py[SQW-1:0];
        r_sqz  <= w_pz[SQW-1:0];
        r_s2_x <= r_s1_x;
        r_s2_y <= r_s1_y;
        r_s2_z <= r_s1_z;
        r_s2_h <= r_s1_h;

        r_sum  <= DIST_W'(w_sum);
        r_s3_x <= r_s2_x;
        r_s3_y <= r_s2_y;
        r_s3_z <= r_s2_z;
        r_s3_h <= r_s2_h;

        if (w_take) begin
            r_best <= r_sum;
            r_bx   <= r_s3_x;
            r_by   <= r_s3_y;
            r_bz   <= r_s3_z;
            r_bh   <= r_s3_h;
        end
    end

    assign o_have        = r_have;
    assign o_best_dist   = r_best;
    assign o_best_handle = r_bh;

endmodule

/* sv/nearest_point_lookup_table_core.sv */
// Nearest point lookup table: a rotating ring of entry cells and one distance unit.
//
// Input words arrive on i_valid/o_ready with a command, a signed position and a
// handle; one result word leaves on o_valid/i_ready for every input word.
// An insert replaces the handle of an entry at the same exact position, else it
// stores a new entry, or reports the table full. A query returns the handle and
// squared distance of the nearest entry, ties going to the smallest position
// (x, then y, then z), or reports an empty table.
// Every word rotates the whole ring once past the head, one entry per cycle,
// so a word goes through the scan, the drain of the distance pipeline and
// one step to register the result before o_valid rises. One word is worked
// on at a time, so a new word is not taken until the block is back in idle;
// the ring length sets the length of the scan.
// The next word is accepted as soon as the block is back in idle, even while
// the previous result still waits in the output register; when the receiver
// stalls, a finished word waits in its last step until the output register
// frees up. Reset clears all valid marks and the entry count at once, so the
// block accepts words in the cycle after reset is released.
module nearest_point_lookup_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_command,
    input  logic signed [15:0]              i_pos_x,
    input  logic signed [15:0]              i_pos_y,
    input  logic signed [15:0]              i_pos_z,
    input  logic [npl_pkg::HANDLE_W-1:0]    i_entry_handle,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [npl_pkg::STATUS_W-1:0]    o_status,
    output logic [npl_pkg::HANDLE_W-1:0]    o_found_handle,
    output logic [npl_pkg::DIST_W-1:0]      o_best_distance_sq
);
    import npl_pkg::*;

    localparam int CW   = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int EW   = 1 + 3 * CW + HANDLE_W;
    localparam int H_LO = 0;
    localparam int Z_LO = HANDLE_W;
    localparam int Y_LO = HANDLE_W + CW;
    localparam int X_LO = HANDLE_W + 2 * CW;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_cmd;
    logic signed [CW-1:0]  r_qx, r_qy, r_qz;
    logic [HANDLE_W-1:0]   r_qh;
    logic [IDXW-1:0]       r_step;
    logic [2:0]            r_drain;
    logic [IDXW:0]         r_count;
    logic                  r_hit;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic [DIST_W-1:0]     r_out_dist;

    logic [EW-1:0]         w_cell [TABLE_DEPTH];
    logic [EW-1:0]         w_head;
    logic [EW-1:0]         w_head_next;
    logic [EW-1:0]         w_new;
    logic                  w_accept;
    logic                  w_shift;
    logic                  w_match;
    logic                  w_full;
    logic                  w_out_free;
    logic                  w_finish;
    logic                  w_store;
    t_dist_ctl             w_dist_ctl;
    logic                  w_have;
    logic [DIST_W-1:0]     w_best_dist;
    logic [HANDLE_W-1:0]   w_best_handle;

    assign w_accept   = i_valid && o_ready;
    assign w_shift    = (r_state == S_SCAN);
    assign w_head     = w_cell[TABLE_DEPTH-1];
    assign w_full     = (r_count == (IDXW+1)'(TABLE_DEPTH));
    assign w_out_free = !r_out_valid || i_ready;
    assign w_finish   = (r_state == S_DONE) && w_out_free;
    assign w_store    = w_finish && (r_cmd == CMD_INSERT) && !r_hit && !w_full;
    assign w_new      = {1'b1, r_qx, r_qy, r_qz, r_qh};

    assign w_match = w_head[EW-1] &&
                     (w_head[X_LO +: CW] == r_qx) &&
                     (w_head[Y_LO +: CW] == r_qy) &&
                     (w_head[Z_LO +: CW] == r_qz);

    // An insert that finds its position replaces the handle as the entry passes.
    always_comb begin
        w_head_next = w_head;
        if (r_cmd == CMD_INSERT && w_match) begin
            w_head_next[H_LO +: HANDLE_W] = r_qh;
        end
    end

    // Valid entries stay packed at the low cells, so a new one goes to cell r_count.
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_ring
        logic [EW-1:0] w_prev;
        if (gi == 0) begin : g_first
            assign w_prev = w_head_next;
        end else begin : g_rest
            assign w_prev = w_cell[gi-1];
        end
        npl_cell #(
            .W (EW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_shift),
            .i_load      (w_store && (r_count == (IDXW+1)'(gi))),
            .i_prev      (w_prev),
            .i_load_data (w_new),
            .o_data      (w_cell[gi])
        );
    end

    assign w_dist_ctl.clear = w_accept;
    assign w_dist_ctl.feed  = w_shift && (r_cmd == CMD_QUERY) && w_head[EW-1];

    npl_dist #(
        .CW (CW)
    ) u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_dist_ctl),
        .i_qx          (r_qx),
        .i_qy          (r_qy),
        .i_qz          (r_qz),
        .i_ex          (w_head[X_LO +: CW]),
        .i_ey          (w_head[Y_LO +: CW]),
        .i_ez          (w_head[Z_LO +: CW]),
        .i_eh          (w_head[H_LO +: HANDLE_W]),
        .o_have        (w_have),
        .o_best_dist   (w_best_dist),
        .o_best_handle (w_best_handle)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_step == IDXW'(TABLE_DEPTH - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain == 3'(DRAIN_CYCLES - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_drain     <= '0;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_step <= '0;
                r_hit  <= 1'b0;
            end else if (w_shift) begin
                r_step <= r_step + 1'b1;
                if (r_cmd == CMD_INSERT && w_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (r_state == S_DRAIN) begin
                r_drain <= r_drain + 1'b1;
            end else begin
                r_drain <= '0;
            end
            if (w_store) begin
                r_count <= r_count + 1'b1;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_qx  <= i_pos_x[CW-1:0];
            r_qy  <= i_pos_y[CW-1:0];
            r_qz  <= i_pos_z[CW-1:0];
            r_qh  <= i_entry_handle;
        end
        if (w_finish) begin
            r_out_handle <= '0;
            r_out_dist   <= '0;
            if (r_cmd == CMD_INSERT) begin
                if (r_hit) begin
                    r_out_status <= ST_REPLACED;
                end else if (w_full) begin
                    r_out_status <= ST_FULL;
                end else begin
                    r_out_status <= ST_INSERTED;
                end
            end else if (w_have) begin
                r_out_status <= ST_HIT;
                r_out_handle <= w_best_handle;
                r_out_dist   <= w_best_dist;
            end else begin
                r_out_status <= ST_EMPTY;
            end
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_found_handle     = r_out_handle;
    assign o_best_distance_sq = r_out_dist;

endmodule

/* dv/nearest_point_lookup_table_core_test.sv */
// Self-checking testbench for the nearest point lookup table core.
module nearest_point_lookup_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import npl_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int RANDOM_WORDS = 1950;
    localparam int TAIL_CYCLES = TABLE_DEPTH + 40;
    localparam int MAX_PRINTED = 100;
    localparam logic [63:0] DIST_ALL_ONES = (64'd1 << DIST_W) - 64'd1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_point;

    typedef struct packed {
        t_status               status;
        logic [HANDLE_W-1:0]   handle;
        logic [DIST_W-1:0]     dist_sq;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_command;
    logic signed [15:0]     i_pos_x;
    logic signed [15:0]     i_pos_y;
    logic signed [15:0]     i_pos_z;
    logic [HANDLE_W-1:0]    i_entry_handle;
    logic                   o_valid;
    logic                   i_ready;
    logic [STATUS_W-1:0]    o_status;
    logic [HANDLE_W-1:0]    o_found_handle;
    logic [DIST_W-1:0]      o_best_distance_sq;

    // Shadow copy of the table contents.
    bit                     shadow_valid [TABLE_DEPTH];
    t_point                 shadow_pos [TABLE_DEPTH];
    logic [HANDLE_W-1:0]    shadow_handle [TABLE_DEPTH];
    int                     shadow_count = 0;

    t_outcome               outcomes_due [$];
    t_outcome               want;
    t_point                 placed [$];
    int                     error_count = 0;
    bit                     idle_off = 1'b0;
    int                     ready_stall = 0;

    nearest_point_lookup_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (16)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_pos_z            (i_pos_z),
        .i_entry_handle     (i_entry_handle),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_found_handle     (o_found_handle),
        .o_best_distance_sq (o_best_distance_sq)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(30, 150);
    endfunction

    function automatic t_point pt(int x, int y, int z);
        t_point p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.z = 16'(z);
        return p;
    endfunction

    // Coarse grid points make equal distances, and so ties, common.
    function automatic t_point random_point();
        t_point p;
        if ($urandom_range(0, 9) < 7) begin
            p = pt((int'($urandom_range(0, 6)) - 3) * 64, (int'($urandom_range(0, 6)) - 3) * 64,
                   (int'($urandom_range(0, 6)) - 3) * 64);
        end else begin
            p = pt($urandom(), $urandom(), $urandom());
        end
        return p;
    endfunction

    function automatic logic [63:0] axis_sq(logic signed [15:0] a, logic signed [15:0] b);
        longint diff;
        diff = longint'(a) - longint'(b);
        return 64'(diff * diff);
    endfunction

    function automatic bit point_less(t_point a, t_point b);
        if (a.x != b.x) begin
            return a.x < b.x;
        end
        if (a.y != b.y) begin
            return a.y < b.y;
        end
        return a.z < b.z;
    endfunction

    function automatic t_outcome apply_to_shadow_table(logic cmd, t_point p, logic [HANDLE_W-1:0] h);
        t_outcome    res;
        int          free_slot;
        int          best_slot;
        bit          have;
        logic [63:0] d;
        logic [63:0] best;
        res.status  = ST_INSERTED;
        res.handle  = '0;
        res.dist_sq = '0;
        if (cmd == CMD_INSERT) begin
            free_slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (shadow_valid[i]) begin
                    if (shadow_pos[i] == p) begin
                        shadow_handle[i] = h;
                        res.status = ST_REPLACED;
                        return res;
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot < 0 || shadow_count >= TABLE_DEPTH) begin
                res.status = ST_FULL;
                return res;
            end
            shadow_valid[free_slot]  = 1'b1;
            shadow_pos[free_slot]    = p;
            shadow_handle[free_slot] = h;
            shadow_count++;
            return res;
        end
        have = 1'b0;
        best = '0;
        best_slot = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (shadow_valid[i]) begin
                d = axis_sq(p.x, shadow_pos[i].x) + axis_sq(p.y, shadow_pos[i].y)
                    + axis_sq(p.z, shadow_pos[i].z);
                if (!have || d < best ||
                    (d == best && point_less(shadow_pos[i], shadow_pos[best_slot]))) begin
                    have = 1'b1;
                    best = d;
                    best_slot = i;
                end
            end
        end
        if (!have) begin
            res.status = ST_EMPTY;
            return res;
        end
        res.status  = ST_HIT;
        res.handle  = shadow_handle[best_slot];
        res.dist_sq = (best > DIST_ALL_ONES) ? '1 : best[DIST_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTED) begin
            $display("%0t: mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Offer one word; the expectation is formed at the edge that accepts it.
    task automatic send_word(input logic cmd, input t_point p, input logic [HANDLE_W-1:0] h,
                             output t_status predicted);
        int       gap;
        t_outcome res;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_pos_x        <= p.x;
        i_pos_y        <= p.y;
        i_pos_z        <= p.z;
        i_entry_handle <= h;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        res = apply_to_shadow_table(cmd, p, h);
        outcomes_due.push_back(res);
        predicted = res.status;
    endtask

    task automatic test_empty_query();
        t_status st;
        send_word(CMD_QUERY, pt(-32768, -32768, -32768), 16'hFFFF, st);
        send_word(CMD_QUERY, pt(32767, 32767, 32767), 16'h0000, st);
    endtask

    task automatic test_insert_extremes();
        t_status st;
        send_word(CMD_INSERT, pt(-32768, -32768, -32768), 16'h0000, st);
        // Only the far corner is stored, so this gives the largest distance.
        send_word(CMD_QUERY, pt(32767, 32767, 32767), 16'h5A5A, st);
        send_word(CMD_INSERT, pt(32767, 32767, 32767), 16'hFFFF, st);
        send_word(CMD_QUERY, pt(32767, -32768, 32767), 16'h0000, st);
    endtask

    task automatic test_replace_handle();
        t_status st;
        send_word(CMD_INSERT, pt(32767, 32767, 32767), 16'h1234, st);
        send_word(CMD_QUERY, pt(32767, 32767, 32767), 16'hFFFF, st);
        send_word(CMD_INSERT, pt(-32768, -32768, -32768), 16'hFFFF, st);
        send_word(CMD_QUERY, pt(-32768, -32768, -32767), 16'h0000, st);
    endtask

    task automatic test_tie_break();
        t_status st;
        send_word(CMD_INSERT, pt(256, 0, 0), 16'h0101, st);
        send_word(CMD_INSERT, pt(0, 256, 0), 16'h0202, st);
        send_word(CMD_INSERT, pt(0, 0, -256), 16'h0303, st);
        send_word(CMD_INSERT, pt(0, -256, 0), 16'h0404, st);
        send_word(CMD_QUERY, pt(0, 0, 0), 16'h0000, st);
        send_word(CMD_INSERT, pt(-256, 0, 0), 16'h0505, st);
        send_word(CMD_QUERY, pt(0, 0, 0), 16'h0000, st);
        // Same x and y, so the tie falls to z.
        send_word(CMD_INSERT, pt(1000, 1000, 1010), 16'h0606, st);
        send_word(CMD_INSERT, pt(1000, 1000, 990), 16'h0707, st);
        send_word(CMD_QUERY, pt(1000, 1000, 1000), 16'h0000, st);
    endtask

    task automatic test_random_mix();
        t_status st;
        t_point  p;
        int      r;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            idle_off = (i >= 300 && i < 450) || (i >= 1500 && i < 1600);
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if ($urandom_range(0, 9) < 3 && placed.size() > 0) begin
                    p = placed[$urandom_range(0, placed.size() - 1)];
                end else begin
                    p = random_point();
                end
                send_word(CMD_QUERY, p, 16'($urandom()), st);
            end else if (r < 92 && placed.size() > 0) begin
                p = placed[$urandom_range(0, placed.size() - 1)];
                send_word(CMD_INSERT, p, 16'($urandom()), st);
            end else begin
                p = random_point();
                send_word(CMD_INSERT, p, 16'($urandom()), st);
                if (st == ST_INSERTED) begin
                    placed.push_back(p);
                end
            end
        end
        idle_off = 1'b0;
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_stall > 0 && !idle_off) begin
                ready_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                ready_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (outcomes_due.size() == 0) begin
                report_mismatch($sformatf("result word with none expected, status %0d", o_status));
            end else begin
                want = outcomes_due.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
                end
                if (o_found_handle !== want.handle) begin
                    report_mismatch($sformatf("found_handle %h, expected %h",
                                              o_found_handle, want.handle));
                end
                if (o_best_distance_sq !== want.dist_sq) begin
                    report_mismatch($sformatf("best_distance_sq %0d, expected %0d",
                                              o_best_distance_sq, want.dist_sq));
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = CMD_INSERT;
        i_pos_x        = '0;
        i_pos_y        = '0;
        i_pos_z        = '0;
        i_entry_handle = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_query();
        test_insert_extremes();
        test_replace_handle();
        test_tie_break();
        test_random_mix();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outcomes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/npl_pkg.sv
sv/npl_cell.sv
sv/npl_dist.sv
sv/nearest_point_lookup_table_core.sv
dv/nearest_point_lookup_table_core_test.sv
